// ===== rtl/bpc_pkg.sv =====
// shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_PRESS_DB   = 2'd1,
		PH_POLL       = 2'd2,
		PH_RELEASE_DB = 2'd3
	} phase_t;

	localparam logic [1:0] EV_QUICK   = 2'd0;
	localparam logic [1:0] EV_LONG    = 2'd1;
	localparam logic [1:0] EV_HELD    = 2'd2;
	localparam logic [1:0] EV_RELEASE = 2'd3;

	localparam logic [1:0] CFG_POLL_PERIOD = 2'd0;
	localparam logic [1:0] CFG_LONG_COUNT  = 2'd1;
	localparam logic [1:0] CFG_QUICK_MAX   = 2'd2;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [15:0] POLL_PERIOD_RST = 16'd50;
	localparam logic [7:0]  LONG_COUNT_RST  = 8'd3;
	localparam logic [7:0]  QUICK_MAX_RST   = 8'd2;
	localparam logic [7:0]  COUNT_MAX       = 8'd255;

	// result queue: four slots, so an item of two events still fits while two others wait
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;
	localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM_FOR_TWO = 3'd2;

	typedef struct packed {
		logic [1:0] event_code;
		logic       last_of_run;
	} result_t;

	// what one item leaves for the result queue
	typedef struct packed {
		logic [1:0] push_n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_if.sv =====
// channel interfaces for pin samples and classified events
`default_nettype none

interface bpc_pin_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

interface bpc_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       last_of_run;

	modport source (output valid, output event_code, output last_of_run, input ready);
	modport sink (input valid, input event_code, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/button_press_classifier_core.sv =====
// button press classifier: debounce, poll count and event generation
//
// pin carries one sample of the active-low button pin per timebase tick.
// evt carries the classified events: quick, long, held and release;
// last_of_run marks the final event caused by one sample.
// a sample is registered on acceptance and classified once it leaves the input
// register, which holds it while the queue lacks room for two events; its events
// then enter a four-entry result queue that drives evt.
// throughput is one sample per cycle while the queue holds at most two events,
// which is the case whenever the receiver keeps up; a release reported as a
// quick press yields two events, a quick press and then a release.
// when the receiver stalls the queue fills and pin.ready drops until room for
// two events frees up; nothing is lost.
// configuration is written through cfg_we/cfg_index/cfg_data while idle.
// reset clears the phase to idle, timer and count to zero, the previous pin
// level to released, empties the queue and loads the default registers.
`default_nettype none

module button_press_classifier_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data,
	bpc_pin_if.sink                                  pin,
	bpc_evt_if.source                                evt
);

	localparam int PW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	logic [15:0]             poll_period_q;
	logic [7:0]              long_count_q;
	logic [7:0]              quick_max_q;

	logic                    valid_s1;
	logic                    level_s1;

	bpc_pkg::phase_t         phase_q, phase_d;
	logic [TIMER_WIDTH-1:0]  timer_q, timer_d, timer_inc, eff_period;
	logic [7:0]              count_q, count_d, count_now;
	logic                    prev_q;

	logic [PW-1:0]           per_wide, tmax_wide;
	logic                    period_end, falling, adv, pin_acc;
	logic                    poll_hit;
	logic [1:0]              poll_code;

	bpc_pkg::push_t          push;
	logic [bpc_pkg::FIFO_CNT_W-1:0] fifo_count;
	logic                    head_valid;
	bpc_pkg::result_t        head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= bpc_pkg::POLL_PERIOD_RST;
			long_count_q  <= bpc_pkg::LONG_COUNT_RST;
			quick_max_q   <= bpc_pkg::QUICK_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::CFG_POLL_PERIOD: poll_period_q <= cfg_data;
				bpc_pkg::CFG_LONG_COUNT:  long_count_q  <= cfg_data[7:0];
				bpc_pkg::CFG_QUICK_MAX:   quick_max_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	assign adv       = valid_s1 && (fifo_count <= bpc_pkg::FIFO_ROOM_FOR_TWO);
	assign pin.ready = !valid_s1 || adv;
	assign pin_acc   = pin.valid && pin.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pin_acc || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (pin_acc) begin
			level_s1 <= pin.pin_level;
		end
	end

	// period length: zero acts as one, clamp to the timer range
	assign per_wide  = PW'(poll_period_q);
	assign tmax_wide = PW'({TIMER_WIDTH{1'b1}});

	always_comb begin
		if (poll_period_q == 16'd0) begin
			eff_period = TIMER_WIDTH'(1);
		end else if (per_wide > tmax_wide) begin
			eff_period = {TIMER_WIDTH{1'b1}};
		end else begin
			eff_period = TIMER_WIDTH'(per_wide);
		end
	end

	assign timer_inc  = timer_q + 1'b1;
	assign period_end = (timer_inc >= eff_period);
	assign falling    = prev_q && !level_s1;

	// poll step with saturating count
	always_comb begin
		count_now = (count_q == bpc_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;
		poll_hit  = 1'b0;
		poll_code = bpc_pkg::EV_HELD;
		if (count_q != bpc_pkg::COUNT_MAX && count_now == long_count_q) begin
			poll_hit  = 1'b1;
			poll_code = bpc_pkg::EV_LONG;
		end else if (count_q == bpc_pkg::COUNT_MAX || count_now > long_count_q) begin
			poll_hit  = 1'b1;
			poll_code = bpc_pkg::EV_HELD;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			bpc_pkg::PH_IDLE: begin
				if (falling) phase_d = bpc_pkg::PH_PRESS_DB;
			end
			bpc_pkg::PH_PRESS_DB: begin
				if (period_end) phase_d = bpc_pkg::PH_POLL;
			end
			bpc_pkg::PH_POLL: begin
				if (period_end && level_s1) phase_d = bpc_pkg::PH_RELEASE_DB;
			end
			bpc_pkg::PH_RELEASE_DB: begin
				if (period_end) phase_d = bpc_pkg::PH_IDLE;
			end
			default: phase_d = bpc_pkg::PH_IDLE;
		endcase
	end

	// timer, count and events
	always_comb begin
		timer_d     = timer_q;
		count_d     = count_q;
		push.push_n = 2'd0;
		push.r0     = '{event_code: bpc_pkg::EV_RELEASE, last_of_run: 1'b1};
		push.r1     = '{event_code: bpc_pkg::EV_RELEASE, last_of_run: 1'b1};
		if (phase_q == bpc_pkg::PH_IDLE) begin
			if (falling) timer_d = '0;
		end else begin
			timer_d = period_end ? '0 : timer_inc;
			if (period_end) begin
				unique case (phase_q)
					bpc_pkg::PH_PRESS_DB: begin
						count_d     = count_now;
						push.push_n = {1'b0, poll_hit};
						push.r0     = '{event_code: poll_code, last_of_run: 1'b1};
					end
					bpc_pkg::PH_POLL: begin
						if (!level_s1) begin
							count_d     = count_now;
							push.push_n = {1'b0, poll_hit};
							push.r0     = '{event_code: poll_code, last_of_run: 1'b1};
						end else if (count_q <= quick_max_q) begin
							push.push_n = 2'd2;
							push.r0     = '{event_code: bpc_pkg::EV_QUICK, last_of_run: 1'b0};
						end else begin
							push.push_n = 2'd1;
						end
					end
					default: count_d = '0;
				endcase
			end
		end
		if (!adv) push.push_n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpc_pkg::PH_IDLE;
			timer_q <= '0;
			count_q <= '0;
			prev_q  <= 1'b1;
		end else if (adv) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			count_q <= count_d;
			prev_q  <= level_s1;
		end
	end

	bpc_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (evt.ready),
		.head_valid (head_valid),
		.head       (head),
		.count      (fifo_count)
	);

	assign evt.valid       = head_valid;
	assign evt.event_code  = head.event_code;
	assign evt.last_of_run = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/bpc_out_fifo.sv =====
// small result queue taking up to two items per cycle
`default_nettype none

module bpc_out_fifo (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bpc_pkg::push_t                    push,
	input  wire logic                              pop,
	output logic                                   head_valid,
	output bpc_pkg::result_t                       head,
	output logic [bpc_pkg::FIFO_CNT_W-1:0]         count
);

	bpc_pkg::result_t                  mem_q [bpc_pkg::FIFO_DEPTH];
	logic [bpc_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [bpc_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [bpc_pkg::FIFO_CNT_W-1:0]    count_q;
	logic                              do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push.push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.push_n == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + bpc_pkg::FIFO_PTR_W'(push.push_n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + bpc_pkg::FIFO_CNT_W'(push.push_n)
				- bpc_pkg::FIFO_CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bpc_checker.sv =====
// port-level checks for the button press classifier
`default_nettype none

module bpc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       evt_valid,
	input wire logic       evt_ready,
	input wire logic [1:0] evt_code,
	input wire logic       evt_last
);

	// a stalled event holds
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(evt_code) && $stable(evt_last))
		else $error("stalled event changed");

	// quick press is never the final event of its tick
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_code == bpc_pkg::EV_QUICK |-> !evt_last)
		else $error("quick press marked last");

	// only quick press may be followed by more events of the same tick
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_last |-> evt_code == bpc_pkg::EV_QUICK)
		else $error("non-final event other than quick press");

	// the release after a quick press is already queued
	assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready && !evt_last
		|=> evt_valid && evt_code == bpc_pkg::EV_RELEASE && evt_last)
		else $error("quick press not followed by release");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.evt_code  (evt.event_code),
	.evt_last  (evt.last_of_run)
);

`default_nettype wire
